// ----- rtl/spcd_pkg.sv -----
package spcd_pkg;

  localparam int NumObjects = 4;
  localparam int NumPairs   = 6;
  localparam int BulletIdx  = 3;
  localparam int CoordW     = 8;
  localparam int RegW       = 8;
  localparam int RegIdxW    = 3;
  localparam int FlagsW     = 8;

  typedef enum logic [RegIdxW-1:0] {
    REG_OBJECT_HALF_WIDTH  = 3'd0,
    REG_OBJECT_HALF_HEIGHT = 3'd1,
    REG_BULLET_HALF_WIDTH  = 3'd2,
    REG_BULLET_HALF_HEIGHT = 3'd3,
    REG_HIDE_LIMIT         = 3'd4
  } spcd_reg_idx_t;

  localparam logic [RegW-1:0] ObjectHalfWidthRst  = 8'd8;
  localparam logic [RegW-1:0] ObjectHalfHeightRst = 8'd16;
  localparam logic [RegW-1:0] BulletHalfWidthRst  = 8'd5;
  localparam logic [RegW-1:0] BulletHalfHeightRst = 8'd10;
  localparam logic [RegW-1:0] HideLimitRst        = 8'd227;

  typedef struct packed {
    logic [RegW-1:0] object_half_width;
    logic [RegW-1:0] object_half_height;
    logic [RegW-1:0] bullet_half_width;
    logic [RegW-1:0] bullet_half_height;
    logic [RegW-1:0] hide_limit;
  } spcd_cfg_t;

  // pairs in flag bit order: (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
  function automatic int spcd_pair_first(input int k);
    int r;
    case (k)
      0, 1, 2: r = 0;
      3, 4:    r = 1;
      default: r = 2;
    endcase
    return r;
  endfunction

  function automatic int spcd_pair_second(input int k);
    int r;
    case (k)
      0:       r = 1;
      1, 3:    r = 2;
      default: r = 3;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/spcd_regs.sv -----
module spcd_regs
  import spcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [RegW-1:0]    cfg_data,
  output spcd_cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.object_half_width  <= ObjectHalfWidthRst;
      cfg.object_half_height <= ObjectHalfHeightRst;
      cfg.bullet_half_width  <= BulletHalfWidthRst;
      cfg.bullet_half_height <= BulletHalfHeightRst;
      cfg.hide_limit         <= HideLimitRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBJECT_HALF_WIDTH:  cfg.object_half_width  <= cfg_data;
        REG_OBJECT_HALF_HEIGHT: cfg.object_half_height <= cfg_data;
        REG_BULLET_HALF_WIDTH:  cfg.bullet_half_width  <= cfg_data;
        REG_BULLET_HALF_HEIGHT: cfg.bullet_half_height <= cfg_data;
        REG_HIDE_LIMIT:         cfg.hide_limit         <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/spcd_pair.sv -----
module spcd_pair
  import spcd_pkg::*;
(
  input  logic [CoordW-1:0] ax,
  input  logic [CoordW-1:0] ay,
  input  logic [CoordW-1:0] bx,
  input  logic [CoordW-1:0] by,
  input  logic              a_visible,
  input  logic              b_visible,
  input  logic [RegW-1:0]   half_w,
  input  logic [RegW-1:0]   half_h,
  output logic              hit
);

  logic [CoordW-1:0] dx;
  logic [CoordW-1:0] dy;

  assign dx  = (ax >= bx) ? (ax - bx) : (bx - ax);
  assign dy  = (ay >= by) ? (ay - by) : (by - ay);
  assign hit = a_visible && b_visible && (dx < half_w) && (dy < half_h);

endmodule

// ----- rtl/sprite_pair_collision_detect_core.sv -----
// Four-object pair collision detector. Each input transfer carries the raw
// x and y positions of four objects (object 3 is the bullet) and yields one
// active-low collision byte: bits 0..5 clear for pairs (0,1) (0,2) (0,3)
// (1,2) (1,3) (2,3) that overlap, bits 6 and 7 always set. An object whose
// x exceeds hide_limit never collides. A new item is taken every cycle
// while the result register is not held by a low m_axis_tready: one
// input register, a combinational subtract-and-compare per pair and
// one result register.
// Configuration writes take effect at the next edge and are meant for idle.
module sprite_pair_collision_detect_core
  import spcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [RegIdxW-1:0]   cfg_index,
  input  logic [RegW-1:0]      cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // obj0_x, obj0_y, obj1_x, obj1_y, obj2_x, obj2_y, obj3_x, obj3_y
  input  logic [2*NumObjects*CoordW-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // collision_flags
  output logic [FlagsW-1:0]    m_axis_tdata
);

  spcd_cfg_t         cfg;
  logic              in_valid;
  logic [CoordW-1:0] px [NumObjects];
  logic [CoordW-1:0] py [NumObjects];
  logic              visible [NumObjects];
  logic [NumPairs-1:0] hits;
  logic              out_advance;
  logic              in_advance;

  spcd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_advance   = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_advance;
  assign in_advance    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      for (int i = 0; i < NumObjects; i++) begin
        px[i] <= s_axis_tdata[2*i*CoordW +: CoordW];
        py[i] <= s_axis_tdata[(2*i+1)*CoordW +: CoordW];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumObjects; i++) begin
      visible[i] = (px[i] <= cfg.hide_limit);
    end
  end

  for (genvar k = 0; k < NumPairs; k++) begin : g_pair
    localparam int A = spcd_pair_first(k);
    localparam int B = spcd_pair_second(k);
    logic [RegW-1:0] hw;
    logic [RegW-1:0] hh;

    if (B == BulletIdx) begin : g_bullet
      assign hw = cfg.bullet_half_width;
      assign hh = cfg.bullet_half_height;
    end else begin : g_object
      assign hw = cfg.object_half_width;
      assign hh = cfg.object_half_height;
    end

    spcd_pair u_pair (
      .ax        (px[A]),
      .ay        (py[A]),
      .bx        (px[B]),
      .by        (py[B]),
      .a_visible (visible[A]),
      .b_visible (visible[B]),
      .half_w    (hw),
      .half_h    (hh),
      .hit       (hits[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      m_axis_tdata <= {{(FlagsW-NumPairs){1'b1}}, ~hits};
    end
  end

endmodule

// ----- tb/sprite_pair_collision_detect_core_tb.sv -----
`timescale 1ns / 1ps

module sprite_pair_collision_detect_core_tb;
  import spcd_pkg::*;

  localparam int ItemW      = 2 * NumObjects * CoordW;
  localparam int NumCfgRegs = 5;
  localparam int CycleLimit = 1_000_000;
  localparam int FarX       = 255;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [RegIdxW-1:0]    cfg_index = '0;
  logic [RegW-1:0]       cfg_data  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // obj0_x, obj0_y, obj1_x, obj1_y, obj2_x, obj2_y, obj3_x, obj3_y
  logic [ItemW-1:0]      s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // collision_flags
  logic [FlagsW-1:0]     m_axis_tdata;

  sprite_pair_collision_detect_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  spcd_cfg_t         box_cfg;
  logic [ItemW-1:0]  pending_positions[$];
  logic [FlagsW-1:0] expected_flags[$];
  logic [FlagsW-1:0] want_flags;
  int                mismatches  = 0;
  int                cycle_count = 0;
  int                send_gap    = 0;
  int                recv_stall  = 0;
  bit                no_idle     = 1'b0;

  function automatic logic [FlagsW-1:0] predict_collision_flags(input logic [ItemW-1:0] pos);
    int px[NumObjects];
    int py[NumObjects];
    int i, a, b, k, dx, dy, hw, hh;
    logic [FlagsW-1:0] flags;
    flags = '1;
    for (i = 0; i < NumObjects; i++) begin
      px[i] = int'(pos[2*i*CoordW +: CoordW]);
      py[i] = int'(pos[(2*i+1)*CoordW +: CoordW]);
    end
    k = 0;
    for (a = 0; a < NumObjects; a++) begin
      for (b = a + 1; b < NumObjects; b++) begin
        if (b == BulletIdx) begin
          hw = int'(box_cfg.bullet_half_width);
          hh = int'(box_cfg.bullet_half_height);
        end else begin
          hw = int'(box_cfg.object_half_width);
          hh = int'(box_cfg.object_half_height);
        end
        dx = px[a] - px[b];
        dy = py[a] - py[b];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (px[a] <= int'(box_cfg.hide_limit) && px[b] <= int'(box_cfg.hide_limit) &&
            dx < hw && dy < hh) begin
          flags[k] = 1'b0;
        end
        k++;
      end
    end
    return flags;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ItemW-1:0] pack_positions(input int x0, y0, x1, y1, x2, y2, x3, y3);
    return {CoordW'(y3), CoordW'(x3), CoordW'(y2), CoordW'(x2),
            CoordW'(y1), CoordW'(x1), CoordW'(y0), CoordW'(x0)};
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // cluster most objects around one spot so pairs land near the box edges
  function automatic logic [ItemW-1:0] random_positions();
    logic [ItemW-1:0] item;
    int base_x, base_y, spread, i, r;
    base_x = $urandom_range(0, 255);
    base_y = $urandom_range(0, 255);
    r = $urandom_range(0, 2);
    spread = (r == 0) ? 8 : (r == 1) ? 24 : 64;
    for (i = 0; i < NumObjects; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        item[2*i*CoordW +: CoordW] =
          CoordW'(clamp_coord(base_x + int'($urandom_range(0, 2*spread)) - spread));
        item[(2*i+1)*CoordW +: CoordW] =
          CoordW'(clamp_coord(base_y + int'($urandom_range(0, 2*spread)) - spread));
      end else begin
        item[2*i*CoordW +: CoordW]     = CoordW'($urandom_range(0, 255));
        item[(2*i+1)*CoordW +: CoordW] = CoordW'($urandom_range(0, 255));
      end
    end
    return item;
  endfunction

  task automatic report_mismatch(input logic [FlagsW-1:0] want, input logic [FlagsW-1:0] got);
    if (mismatches < 10)
      $display("mismatch at cycle %0d: expected %h, got %h", cycle_count, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid)
        expected_flags.push_back(predict_collision_flags(s_axis_tdata));
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_positions.size() != 0) begin
        s_axis_tdata  <= pending_positions.pop_front();
        s_axis_tvalid <= 1'b1;
        send_gap = no_idle ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_flags.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result at cycle %0d: %h", cycle_count, m_axis_tdata);
          mismatches++;
        end else begin
          want_flags = expected_flags.pop_front();
          if (want_flags !== m_axis_tdata) report_mismatch(want_flags, m_axis_tdata);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall = no_idle ? 0 : pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_OBJECT_HALF_WIDTH:  box_cfg.object_half_width  = val;
      REG_OBJECT_HALF_HEIGHT: box_cfg.object_half_height = val;
      REG_BULLET_HALF_WIDTH:  box_cfg.bullet_half_width  = val;
      REG_BULLET_HALF_HEIGHT: box_cfg.bullet_half_height = val;
      REG_HIDE_LIMIT:         box_cfg.hide_limit         = val;
      default: ;
    endcase
  endtask

  task automatic set_boxes(input int ow, oh, bw, bh, hide);
    write_reg(REG_OBJECT_HALF_WIDTH,  RegW'(ow));
    write_reg(REG_OBJECT_HALF_HEIGHT, RegW'(oh));
    write_reg(REG_BULLET_HALF_WIDTH,  RegW'(bw));
    write_reg(REG_BULLET_HALF_HEIGHT, RegW'(bh));
    write_reg(REG_HIDE_LIMIT,         RegW'(hide));
  endtask

  task automatic queue_random(input int count);
    int i;
    for (i = 0; i < count; i++) pending_positions.push_back(random_positions());
  endtask

  // hold until every transfer is out and every result is back
  task automatic drain();
    @(negedge clk);
    while (pending_positions.size() != 0 || s_axis_tvalid || expected_flags.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    int ph, k;
    box_cfg.object_half_width  = ObjectHalfWidthRst;
    box_cfg.object_half_height = ObjectHalfHeightRst;
    box_cfg.bullet_half_width  = BulletHalfWidthRst;
    box_cfg.bullet_half_height = BulletHalfHeightRst;
    box_cfg.hide_limit         = HideLimitRst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_positions.push_back(pack_positions(0, 0, 0, 0, 0, 0, 0, 0));
    pending_positions.push_back(pack_positions(255, 255, 255, 255, 255, 255, 255, 255));
    pending_positions.push_back(pack_positions(100, 100, 107, 115, FarX, 0, FarX, 0));
    pending_positions.push_back(pack_positions(100, 100, 108, 100, FarX, 0, FarX, 0));
    pending_positions.push_back(pack_positions(100, 100, 100, 116, FarX, 0, FarX, 0));
    pending_positions.push_back(pack_positions(100, 100, 107, 85, FarX, 0, FarX, 0));
    pending_positions.push_back(pack_positions(50, 50, FarX, 0, FarX, 0, 54, 59));
    pending_positions.push_back(pack_positions(50, 50, FarX, 0, FarX, 0, 55, 50));
    pending_positions.push_back(pack_positions(50, 50, FarX, 0, FarX, 0, 50, 60));
    pending_positions.push_back(pack_positions(FarX, 0, 20, 200, 27, 215, FarX, 0));
    pending_positions.push_back(pack_positions(FarX, 0, 20, 200, FarX, 0, 16, 191));
    pending_positions.push_back(pack_positions(FarX, 0, FarX, 0, 200, 0, 204, 9));
    pending_positions.push_back(pack_positions(227, 30, 227, 30, FarX, 0, FarX, 0));
    pending_positions.push_back(pack_positions(228, 30, 228, 30, FarX, 0, FarX, 0));
    pending_positions.push_back(pack_positions(227, 30, 228, 30, FarX, 0, FarX, 0));
    pending_positions.push_back(pack_positions(0, 0, 227, 255, 0, 255, 227, 0));
    pending_positions.push_back(pack_positions(0, 255, 0, 255, 0, 255, 0, 255));
    pending_positions.push_back(pack_positions(5, 3, 0, 0, 10, 18, 2, 8));
    queue_random(200);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_boxes(0, 0, 0, 0, 255);
        1: set_boxes(255, 255, 255, 255, 255);
        2: set_boxes(1, 1, 1, 1, 0);
        3: set_boxes(255, 255, 1, 1, 128);
        4: begin
          for (k = NumCfgRegs; k < (1 << RegIdxW); k++)
            write_reg(RegIdxW'(k), RegW'($urandom_range(0, 255)));
          set_boxes(ObjectHalfWidthRst, ObjectHalfHeightRst, BulletHalfWidthRst,
                    BulletHalfHeightRst, HideLimitRst);
        end
        default: set_boxes($urandom_range(0, 40), $urandom_range(0, 40),
                           $urandom_range(0, 40), $urandom_range(0, 40),
                           $urandom_range(180, 255));
      endcase
      @(negedge clk);
      no_idle = (ph == 1) || ($urandom_range(0, 3) == 0);
      queue_random(190);
      drain();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_flags.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
